@@ sv/assert_macros.svh @@
// Assertion helpers for the files that check their own logic.
// Both macros take a label, the clock, the active-low reset, a trigger and a consequence.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_SAME(label, clk, rst_n, trig, cons)
`define ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif
`endif

@@ sv/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the heap allocator controller and datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int          WORDS      = 32768;
    localparam int          WADDR_W    = 15;
    localparam int          CNT_W      = 17;
    localparam logic [16:0] WALK_LIMIT = 17'h10000;

    typedef enum logic [2:0] {
        FN_ALLOC   = 3'd0,
        FN_FREE    = 3'd1,
        FN_TOTAL   = 3'd2,
        FN_LARGEST = 3'd3,
        FN_SAVE    = 3'd4,
        FN_RESTORE = 3'd5
    } t_func;

    typedef enum logic [5:0] {
        S_CLR, S_IH1, S_IH2, S_IDLE, S_DISP,
        S_A_INIT, S_A_CHK, S_A_RDS, S_A_RDN, S_A_TST, S_A_WH,
        S_A_SP1, S_A_SP2, S_A_SP3, S_A_SZ,
        S_F_INIT, S_F_LOOP, S_F_RDN, S_F_H1, S_F_H2, S_F_H5,
        S_F_M1, S_F_M2, S_F_M3, S_F_M4, S_F_M5, S_F_M6, S_F_M7, S_F_M9, S_F_M10,
        S_F_M11, S_F_M12, S_F_M13, S_F_M14, S_F_OK,
        S_W_INIT, S_W_CHK, S_W_RDS, S_W_RDN,
        S_SAVE, S_R_1, S_R_2, S_R_3, S_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_TAKE, OP_A_INIT, OP_A_STEP, OP_LD_BS, OP_LD_NX, OP_NEED_BS,
        OP_NX_REST, OP_A_DONE, OP_F_INIT, OP_F_STEP, OP_LD_SM, OP_LD_SM_HEAD,
        OP_LD_SP, OP_LD_SN, OP_LD_NN, OP_M_PREV, OP_F_OK, OP_W_INIT, OP_W_SIZE,
        OP_W_NEXT, OP_SAVE, OP_RESTORE, OP_FIN
    } t_op;

    typedef enum logic [3:0] {
        A_CUR, A_CUR2, A_PREV, A_PREV2, A_REST, A_REST2, A_M, A_M2,
        A_FIRST, A_FIRST2, A_BASE, A_BASE2
    } t_asel;

    typedef enum logic [3:0] {
        D_NX, D_REST, D_BS_NEED, D_NEED, D_M, D_CUR, D_SP_SM, D_SM_SN, D_NN,
        D_END_FIRST, D_END, D_END_BASE
    } t_wsel;

    typedef struct packed {
        logic  in_rdy;
        logic  clr;
        logic  mem_req;
        logic  mem_wr;
        t_asel asel;
        t_wsel wsel;
        t_op   op;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  mem_done;
        logic  clr_last;
        logic  cur_end;
        logic  cnt_lim;
        logic  fit;
        logic  whole;
        logic  cur_lt_m;
        logic  cur_eq_m;
        logic  prev_eq_cur;
        logic  m_bad;
        logic  adj_prev;
        logic  adj_next;
        logic  mark_end;
        logic  out_busy;
    } t_sts;

endpackage

@@ sv/ffha_ram.sv @@
// ----------------------------------------------------------------------------
// ffha_ram
// Single-port RAM with one write or read address per cycle and registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;

endmodule

@@ sv/ffha_dp.sv @@
// ----------------------------------------------------------------------------
// ffha_dp
// Allocator datapath: walk registers, header byte access engine and results.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; #(
    parameter int HEAP_BASE = 800,
    parameter int HEAP_END  = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_req_size,
    input  logic [15:0] i_block_pos,
    input  logic        i_out_stall,
    output logic        o_valid,
    output logic [15:0] o_address,
    output logic [15:0] o_amount,
    output logic        o_ok
);

    localparam logic [15:0] BASE = HEAP_BASE[15:0];
    localparam logic [15:0] HEND = HEAP_END[15:0];

    t_func              r_func;
    logic [15:0]        r_req, r_pos, r_prev, r_cur, r_nx, r_bs, r_m;
    logic [15:0]        r_sm, r_sp, r_sn, r_nn, r_first, r_mark;
    logic [16:0]        r_need;
    logic [CNT_W-1:0]   r_cnt;
    logic [15:0]        r_addr, r_amt, r_o_addr, r_o_amt;
    logic               r_ok, r_o_ok, r_o_valid;
    logic               r_mph, r_mk;
    logic [7:0]         r_rd_lo;
    logic [WADDR_W-1:0] r_clr;

    logic [15:0]        maddr, wdata, rest, ba, rd, ram_q, ram_wdata;
    logic [WADDR_W-1:0] ram_addr;
    logic [7:0]         byte_q, wbyte;
    logic [16:0]        tot_sum;
    logic [17:0]        need_p4;
    logic               ram_we, mem_done, fire;

    assign rest = r_cur + r_need[15:0];

    always_comb begin
        case (i_cmd.asel)
            A_CUR:    maddr = r_cur;
            A_CUR2:   maddr = r_cur + 16'd2;
            A_PREV:   maddr = r_prev;
            A_PREV2:  maddr = r_prev + 16'd2;
            A_REST:   maddr = rest;
            A_REST2:  maddr = rest + 16'd2;
            A_M:      maddr = r_m;
            A_M2:     maddr = r_m + 16'd2;
            A_FIRST:  maddr = r_first;
            A_FIRST2: maddr = r_first + 16'd2;
            A_BASE:   maddr = BASE;
            A_BASE2:  maddr = BASE + 16'd2;
            default:  maddr = r_cur;
        endcase
    end

    always_comb begin
        case (i_cmd.wsel)
            D_NX:        wdata = r_nx;
            D_REST:      wdata = rest;
            D_BS_NEED:   wdata = r_bs - r_need[15:0];
            D_NEED:      wdata = r_need[15:0];
            D_M:         wdata = r_m;
            D_CUR:       wdata = r_cur;
            D_SP_SM:     wdata = r_sp + r_sm;
            D_SM_SN:     wdata = r_sm + r_sn;
            D_NN:        wdata = r_nn;
            D_END_FIRST: wdata = HEND - r_first;
            D_END:       wdata = HEND;
            D_END_BASE:  wdata = HEND - BASE;
            default:     wdata = r_nx;
        endcase
    end

    // Each 16-bit header access is two byte steps, each a word read followed by
    // the byte capture or a merged word write; headers may sit at odd positions.
    assign ba        = maddr + {15'd0, r_mk};
    assign byte_q    = ba[0] ? ram_q[15:8] : ram_q[7:0];
    assign wbyte     = r_mk ? wdata[15:8] : wdata[7:0];
    assign ram_addr  = i_cmd.clr ? r_clr : ba[15:1];
    assign ram_we    = i_cmd.clr | (r_mph & i_cmd.mem_wr);
    assign ram_wdata = i_cmd.clr ? 16'd0
                     : (ba[0] ? {wbyte, ram_q[7:0]} : {ram_q[15:8], wbyte});
    assign mem_done  = r_mph & r_mk;
    assign rd        = {byte_q, r_rd_lo};
    assign fire      = !i_cmd.mem_req || mem_done;

    ffha_ram #(.WIDTH(16), .DEPTH(WORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    assign tot_sum = {1'b0, r_amt} + {1'b0, rd};
    assign need_p4 = {1'b0, r_need} + 18'd4;

    always_ff @(posedge i_clk) begin
        if (r_mph && !r_mk) begin
            r_rd_lo <= byte_q;
        end
        if (fire) begin
            case (i_cmd.op)
                OP_TAKE: begin
                    r_func <= t_func'(i_func);
                    r_req  <= i_req_size;
                    r_pos  <= i_block_pos;
                    r_addr <= 16'd0;
                    r_amt  <= 16'd0;
                    r_ok   <= 1'b0;
                end
                OP_A_INIT: begin
                    r_need <= {1'b0, r_req} + 17'd2 + {16'd0, r_req[0]};
                    r_prev <= r_first;
                    r_cur  <= r_first;
                    r_cnt  <= '0;
                end
                OP_A_STEP: begin
                    r_prev <= r_cur;
                    r_cur  <= r_nx;
                end
                OP_LD_BS: r_bs <= rd;
                OP_LD_NX: begin
                    r_nx  <= rd;
                    r_cnt <= r_cnt + 1'b1;
                end
                OP_NEED_BS: r_need <= {1'b0, r_bs};
                OP_NX_REST: r_nx <= rest;
                OP_A_DONE: begin
                    r_addr <= r_cur;
                    r_amt  <= r_need[15:0];
                    r_ok   <= 1'b1;
                end
                OP_F_INIT: begin
                    r_m    <= r_pos;
                    r_prev <= r_first;
                    r_cur  <= r_first;
                    r_cnt  <= '0;
                end
                OP_F_STEP: begin
                    r_prev <= r_cur;
                    r_cur  <= rd;
                    r_cnt  <= r_cnt + 1'b1;
                end
                OP_LD_SM, OP_LD_SM_HEAD: r_sm <= rd;
                OP_LD_SP: r_sp <= rd;
                OP_LD_SN: r_sn <= rd;
                OP_LD_NN: r_nn <= rd;
                OP_M_PREV: r_m <= r_prev;
                OP_F_OK: begin
                    r_addr <= r_pos;
                    r_ok   <= 1'b1;
                end
                OP_W_INIT: begin
                    r_cur <= r_first;
                    r_cnt <= '0;
                    r_ok  <= (r_func == FN_TOTAL);
                end
                OP_W_SIZE: begin
                    if (r_func == FN_TOTAL) begin
                        r_amt <= tot_sum[16] ? 16'hffff : tot_sum[15:0];
                    end else if (rd > r_amt) begin
                        r_amt  <= rd;
                        r_addr <= r_cur;
                        r_ok   <= 1'b1;
                    end
                end
                OP_W_NEXT: begin
                    r_cur <= rd;
                    r_cnt <= r_cnt + 1'b1;
                end
                OP_SAVE: begin
                    r_addr <= r_first;
                    r_ok   <= 1'b1;
                end
                OP_RESTORE: begin
                    r_addr <= r_mark;
                    r_ok   <= 1'b1;
                    r_amt  <= (r_mark < HEND) ? HEND - r_mark : 16'd0;
                end
                OP_FIN: begin
                    r_o_addr <= r_addr;
                    r_o_amt  <= r_amt;
                    r_o_ok   <= r_ok;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first   <= BASE;
            r_mark    <= BASE;
            r_o_valid <= 1'b0;
            r_mph     <= 1'b0;
            r_mk      <= 1'b0;
            r_clr     <= '0;
        end else begin
            if (r_mph) begin
                r_mph <= 1'b0;
                r_mk  <= ~r_mk;
            end else if (i_cmd.mem_req) begin
                r_mph <= 1'b1;
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_o_valid && !i_out_stall && !(fire && i_cmd.op == OP_FIN)) begin
                r_o_valid <= 1'b0;
            end
            if (fire) begin
                case (i_cmd.op)
                    OP_A_DONE: begin
                        if (r_cur == r_first) begin
                            r_first <= r_nx;
                        end
                    end
                    OP_LD_SM_HEAD: r_first <= r_m;
                    OP_SAVE:       r_mark <= r_first;
                    OP_RESTORE:    r_first <= r_mark;
                    OP_FIN:        r_o_valid <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        o_sts.func        = r_func;
        o_sts.mem_done    = mem_done;
        o_sts.clr_last    = &r_clr;
        o_sts.cur_end     = r_cur >= HEND;
        o_sts.cnt_lim     = r_cnt == WALK_LIMIT;
        o_sts.fit         = {1'b0, r_bs} >= r_need;
        o_sts.whole       = {2'b0, r_bs} <= need_p4;
        o_sts.cur_lt_m    = r_cur < r_m;
        o_sts.cur_eq_m    = r_cur == r_m;
        o_sts.prev_eq_cur = r_prev == r_cur;
        o_sts.m_bad       = (r_pos < BASE) || (r_pos >= HEND);
        o_sts.adj_prev    = ({1'b0, r_prev} + {1'b0, r_sp}) == {1'b0, r_m};
        o_sts.adj_next    = (r_cur < HEND) && (({1'b0, r_m} + {1'b0, r_sm}) == {1'b0, r_cur});
        o_sts.mark_end    = r_mark >= HEND;
        o_sts.out_busy    = r_o_valid && i_out_stall;
    end

    assign o_valid   = r_o_valid;
    assign o_address = r_o_addr;
    assign o_amount  = r_o_amt;
    assign o_ok      = r_o_ok;

endmodule

@@ sv/ffha_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffha_ctrl
// Allocator sequencer: clearing pass, operation dispatch and free-list walks.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:    if (i_sts.clr_last) n_state = S_IH1;
            S_IH1:    if (i_sts.mem_done) n_state = S_IH2;
            S_IH2:    if (i_sts.mem_done) n_state = S_IDLE;
            S_IDLE:   if (i_valid) n_state = S_DISP;
            S_DISP: begin
                case (i_sts.func)
                    FN_ALLOC:   n_state = S_A_INIT;
                    FN_FREE:    n_state = S_F_INIT;
                    FN_TOTAL:   n_state = S_W_INIT;
                    FN_LARGEST: n_state = S_W_INIT;
                    FN_SAVE:    n_state = S_SAVE;
                    FN_RESTORE: n_state = S_R_1;
                    default:    n_state = S_FIN;
                endcase
            end
            S_A_INIT: n_state = S_A_CHK;
            S_A_CHK:  n_state = (i_sts.cur_end || i_sts.cnt_lim) ? S_FIN : S_A_RDS;
            S_A_RDS:  if (i_sts.mem_done) n_state = S_A_RDN;
            S_A_RDN:  if (i_sts.mem_done) n_state = S_A_TST;
            S_A_TST: begin
                if (i_sts.fit) begin
                    n_state = i_sts.whole ? S_A_WH : S_A_SP1;
                end else begin
                    n_state = S_A_CHK;
                end
            end
            S_A_WH:   if (i_sts.mem_done) n_state = S_A_SZ;
            S_A_SP1:  if (i_sts.mem_done) n_state = S_A_SP2;
            S_A_SP2:  if (i_sts.mem_done) n_state = S_A_SP3;
            S_A_SP3:  if (i_sts.mem_done) n_state = S_A_SZ;
            S_A_SZ:   if (i_sts.mem_done) n_state = S_FIN;
            S_F_INIT: n_state = i_sts.m_bad ? S_FIN : S_F_LOOP;
            S_F_LOOP: begin
                if (i_sts.cur_lt_m) begin
                    n_state = i_sts.cnt_lim ? S_FIN : S_F_RDN;
                end else if (i_sts.cur_eq_m) begin
                    n_state = S_FIN;
                end else begin
                    n_state = i_sts.prev_eq_cur ? S_F_H1 : S_F_M1;
                end
            end
            S_F_RDN:  if (i_sts.mem_done) n_state = S_F_LOOP;
            S_F_H1:   if (i_sts.mem_done) n_state = S_F_H2;
            S_F_H2:   n_state = i_sts.adj_next ? S_F_M11 : S_F_H5;
            S_F_H5:   if (i_sts.mem_done) n_state = S_F_OK;
            S_F_M1:   if (i_sts.mem_done) n_state = S_F_M2;
            S_F_M2:   if (i_sts.mem_done) n_state = S_F_M3;
            S_F_M3:   if (i_sts.mem_done) n_state = S_F_M4;
            S_F_M4:   if (i_sts.mem_done) n_state = S_F_M5;
            S_F_M5:   n_state = i_sts.adj_prev ? S_F_M6 : S_F_M9;
            S_F_M6:   if (i_sts.mem_done) n_state = S_F_M7;
            S_F_M7:   if (i_sts.mem_done) n_state = S_F_M9;
            S_F_M9:   if (i_sts.mem_done) n_state = S_F_M10;
            S_F_M10:  n_state = i_sts.adj_next ? S_F_M11 : S_F_OK;
            S_F_M11:  if (i_sts.mem_done) n_state = S_F_M12;
            S_F_M12:  if (i_sts.mem_done) n_state = S_F_M13;
            S_F_M13:  if (i_sts.mem_done) n_state = S_F_M14;
            S_F_M14:  if (i_sts.mem_done) n_state = S_F_OK;
            S_F_OK:   n_state = S_FIN;
            S_W_INIT: n_state = S_W_CHK;
            S_W_CHK:  n_state = (i_sts.cur_end || i_sts.cnt_lim) ? S_FIN : S_W_RDS;
            S_W_RDS:  if (i_sts.mem_done) n_state = S_W_RDN;
            S_W_RDN:  if (i_sts.mem_done) n_state = S_W_CHK;
            S_SAVE:   n_state = S_FIN;
            S_R_1:    n_state = i_sts.mark_end ? S_FIN : S_R_2;
            S_R_2:    if (i_sts.mem_done) n_state = S_R_3;
            S_R_3:    if (i_sts.mem_done) n_state = S_FIN;
            S_FIN:    if (!i_sts.out_busy) n_state = S_IDLE;
            default:  n_state = S_CLR;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.asel    = A_CUR;
        o_cmd.wsel    = D_NX;
        o_cmd.op      = OP_NONE;
        case (r_state)
            S_CLR: o_cmd.clr = 1'b1;
            S_IH1: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_BASE;  o_cmd.wsel = D_END_BASE;
            end
            S_IH2: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_BASE2; o_cmd.wsel = D_END;
            end
            S_IDLE: begin
                o_cmd.in_rdy = 1'b1;
                if (i_valid) o_cmd.op = OP_TAKE;
            end
            S_A_INIT: o_cmd.op = OP_A_INIT;
            S_A_RDS: begin
                o_cmd.mem_req = 1'b1; o_cmd.asel = A_CUR; o_cmd.op = OP_LD_BS;
            end
            S_A_RDN: begin
                o_cmd.mem_req = 1'b1; o_cmd.asel = A_CUR2; o_cmd.op = OP_LD_NX;
            end
            S_A_TST: if (!i_sts.fit) o_cmd.op = OP_A_STEP;
            S_A_WH: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_PREV2; o_cmd.wsel = D_NX; o_cmd.op = OP_NEED_BS;
            end
            S_A_SP1: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_PREV2; o_cmd.wsel = D_REST;
            end
            S_A_SP2: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_REST;  o_cmd.wsel = D_BS_NEED;
            end
            S_A_SP3: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_REST2; o_cmd.wsel = D_NX; o_cmd.op = OP_NX_REST;
            end
            S_A_SZ: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_CUR;   o_cmd.wsel = D_NEED; o_cmd.op = OP_A_DONE;
            end
            S_F_INIT: o_cmd.op = OP_F_INIT;
            S_F_RDN: begin
                o_cmd.mem_req = 1'b1; o_cmd.asel = A_CUR2; o_cmd.op = OP_F_STEP;
            end
            S_F_H1: begin
                o_cmd.mem_req = 1'b1; o_cmd.asel = A_M; o_cmd.op = OP_LD_SM_HEAD;
            end
            S_F_H5: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_M2;    o_cmd.wsel = D_CUR;
            end
            S_F_M1: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_PREV2; o_cmd.wsel = D_M;
            end
            S_F_M2: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_M2;    o_cmd.wsel = D_CUR;
            end
            S_F_M3: begin
                o_cmd.mem_req = 1'b1; o_cmd.asel = A_PREV; o_cmd.op = OP_LD_SP;
            end
            S_F_M4, S_F_M9: begin
                o_cmd.mem_req = 1'b1; o_cmd.asel = A_M; o_cmd.op = OP_LD_SM;
            end
            S_F_M6: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_PREV;  o_cmd.wsel = D_SP_SM;
            end
            S_F_M7: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_PREV2; o_cmd.wsel = D_CUR; o_cmd.op = OP_M_PREV;
            end
            S_F_M11: begin
                o_cmd.mem_req = 1'b1; o_cmd.asel = A_CUR; o_cmd.op = OP_LD_SN;
            end
            S_F_M12: begin
                o_cmd.mem_req = 1'b1; o_cmd.asel = A_CUR2; o_cmd.op = OP_LD_NN;
            end
            S_F_M13: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_M;     o_cmd.wsel = D_SM_SN;
            end
            S_F_M14: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_M2;    o_cmd.wsel = D_NN;
            end
            S_F_OK:   o_cmd.op = OP_F_OK;
            S_W_INIT: o_cmd.op = OP_W_INIT;
            S_W_RDS: begin
                o_cmd.mem_req = 1'b1; o_cmd.asel = A_CUR; o_cmd.op = OP_W_SIZE;
            end
            S_W_RDN: begin
                o_cmd.mem_req = 1'b1; o_cmd.asel = A_CUR2; o_cmd.op = OP_W_NEXT;
            end
            S_SAVE: o_cmd.op = OP_SAVE;
            S_R_1:  o_cmd.op = OP_RESTORE;
            S_R_2: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_FIRST; o_cmd.wsel = D_END_FIRST;
            end
            S_R_3: begin
                o_cmd.mem_req = 1'b1; o_cmd.mem_wr = 1'b1;
                o_cmd.asel = A_FIRST2; o_cmd.wsel = D_END;
            end
            S_FIN: if (!i_sts.out_busy) o_cmd.op = OP_FIN;
            default: ;
        endcase
    end

endmodule

@@ sv/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit free-list heap allocator with coalescing over a 64 KiB byte heap.
// ----------------------------------------------------------------------------
// The block takes one operation at a time. After reset it clears the heap
// RAM, one word a cycle over all 32768 words, and then writes the initial
// header, stalling the input until then. Each 16-bit header access goes
// through the single RAM port as two byte steps. Allocate reads each free
// block that it visits and then writes a whole-block grant or a split;
// free walks the free blocks below the freed one, then links and merges;
// total and largest walk the free list; save and restore move the list
// head and the mark, restore also writing a fresh header. The result waits
// in an output register while the next transaction is accepted.
module first_fit_heap_allocator import ffha_pkg::*; #(
    parameter int HEAP_BASE = 800,
    parameter int HEAP_END  = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [15:0] i_req_size,
    input  logic [15:0] i_block_pos,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_address,
    output logic [15:0] o_amount,
    output logic        o_ok
);

`include "assert_macros.svh"

    t_cmd w_cmd;
    t_sts w_sts;

    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ffha_dp #(.HEAP_BASE(HEAP_BASE), .HEAP_END(HEAP_END)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_func      (i_func),
        .i_req_size  (i_req_size),
        .i_block_pos (i_block_pos),
        .i_out_stall (i_stall),
        .o_valid     (o_valid),
        .o_address   (o_address),
        .o_amount    (o_amount),
        .o_ok        (o_ok)
    );

    assign o_stall = !w_cmd.in_rdy;

    // The byte engine must only finish a header access that is still requested.
    `ASSERT_SAME(a_done_req, i_clk, i_rst_n, w_sts.mem_done, w_cmd.mem_req)
    // After a transaction is taken, the block is busy in the next cycle.
    `ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // A new result appears only after the result load step.
    `ASSERT_SAME(a_fin, i_clk, i_rst_n, $rose(o_valid), $past(w_cmd.op == OP_FIN))

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Heap allocator testbench
// Drives allocate, free, query, save and restore transactions into the
// first-fit allocator. A shadow heap predicts every result that the
// directed table leaves open, and each result is compared field by field
// as it arrives. A short directed table comes first, followed by random
// traffic that mostly frees held blocks, keeping the free list well formed.
// ----------------------------------------------------------------------------
module testbench;
    import ffha_pkg::*;

    localparam int unsigned BASE_POS  = 800;
    localparam int unsigned END_POS   = 65535;
    localparam int unsigned STEP_CAP  = 65536;
    localparam logic [2:0]  FN_BAD6   = 3'd6;
    localparam logic [2:0]  FN_BAD7   = 3'd7;
    localparam int          N_RANDOM  = 1825;
    localparam int          IDLE_CAP  = 100000;

    typedef struct {
        logic [2:0]  fn;
        logic [15:0] req;
        logic [15:0] pos;
        bit          typed;
        logic [15:0] addr;
        logic [15:0] amt;
        logic        ok;
    } t_row;

    typedef struct {
        logic [15:0] addr;
        logic [15:0] amt;
        logic        ok;
    } t_result;

    typedef struct {
        int unsigned pos;
        int unsigned size;
    } t_held;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [2:0]  i_func = '0;
    logic [15:0] i_req_size = '0;
    logic [15:0] i_block_pos = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_address;
    logic [15:0] o_amount;
    logic        o_ok;

    logic [15:0] shadow_heap [WORDS];
    int unsigned shadow_first;
    int unsigned shadow_mark;
    t_result     pending_results[$];
    t_held       held_blocks[$];
    int          err_cnt = 0;
    int          idle_cycles = 0;
    bit          sink_quiet = 1'b0;
    int          sink_hold = 0;

    first_fit_heap_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_req_size  (i_req_size),
        .i_block_pos (i_block_pos),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_address   (o_address),
        .o_amount    (o_amount),
        .o_ok        (o_ok)
    );

    always #6 i_clk = ~i_clk;

    function automatic int unsigned heap_rd8(int unsigned p);
        logic [15:0] w;
        p = p & 16'hffff;
        w = shadow_heap[p >> 1];
        return p[0] ? w[15:8] : w[7:0];
    endfunction

    function automatic void heap_wr8(int unsigned p, int unsigned v);
        p = p & 16'hffff;
        if (p[0]) shadow_heap[p >> 1][15:8] = v[7:0];
        else shadow_heap[p >> 1][7:0] = v[7:0];
    endfunction

    function automatic int unsigned heap_rd16(int unsigned p);
        return heap_rd8(p) | (heap_rd8(p + 1) << 8);
    endfunction

    function automatic void heap_wr16(int unsigned p, int unsigned v);
        heap_wr8(p, v);
        heap_wr8(p + 1, v >> 8);
    endfunction

    function automatic int unsigned blk_size(int unsigned p);
        return heap_rd16(p);
    endfunction

    function automatic int unsigned blk_link(int unsigned p);
        return heap_rd16(p + 2);
    endfunction

    function automatic void heap_reset();
        foreach (shadow_heap[i]) shadow_heap[i] = '0;
        shadow_first = BASE_POS;
        shadow_mark  = BASE_POS;
        heap_wr16(BASE_POS, END_POS - BASE_POS);
        heap_wr16(BASE_POS + 2, END_POS);
    endfunction

    function automatic bit heap_grant(int unsigned req, output int unsigned addr,
                                      output int unsigned amt);
        int unsigned need, prev, cur, n, bs, nx, rest;
        need = req + 2 + (req & 1);
        prev = shadow_first;
        cur  = shadow_first;
        n    = 0;
        addr = 0;
        amt  = 0;
        while (cur < END_POS && n < STEP_CAP) begin
            bs = blk_size(cur);
            nx = blk_link(cur);
            n++;
            if (bs >= need) begin
                if (bs <= need + 4) begin
                    need = bs;
                    heap_wr16(prev + 2, nx);
                end else begin
                    rest = (cur + need) & 16'hffff;
                    heap_wr16(prev + 2, rest);
                    heap_wr16(rest, (bs - need) & 16'hffff);
                    heap_wr16(rest + 2, nx);
                    nx = rest;
                end
                heap_wr16(cur, need & 16'hffff);
                if (cur == shadow_first) shadow_first = nx;
                addr = cur;
                amt  = need & 16'hffff;
                return 1'b1;
            end
            prev = cur;
            cur  = nx;
        end
        return 1'b0;
    endfunction

    function automatic bit heap_release(int unsigned m);
        int unsigned prev, nxt, n;
        prev = shadow_first;
        nxt  = shadow_first;
        n    = 0;
        if (m < BASE_POS || m >= END_POS) return 1'b0;
        while (nxt < m) begin
            n++;
            if (n > STEP_CAP) return 1'b0;
            prev = nxt;
            nxt  = blk_link(prev);
        end
        if (nxt == m) return 1'b0;
        if (prev == nxt) begin
            shadow_first = m;
            if (nxt < END_POS && m + blk_size(m) == nxt) begin
                heap_wr16(m, blk_size(m) + blk_size(nxt));
                heap_wr16(m + 2, blk_link(nxt));
            end else begin
                heap_wr16(m + 2, nxt);
            end
            return 1'b1;
        end
        heap_wr16(prev + 2, m);
        heap_wr16(m + 2, nxt);
        if (prev + blk_size(prev) == m) begin
            heap_wr16(prev, blk_size(prev) + blk_size(m));
            heap_wr16(prev + 2, nxt);
            m = prev;
        end
        if (nxt < END_POS && m + blk_size(m) == nxt) begin
            heap_wr16(m, blk_size(m) + blk_size(nxt));
            heap_wr16(m + 2, blk_link(nxt));
        end
        return 1'b1;
    endfunction

    // Works out the result of one transaction and keeps the list of held
    // blocks in step with the shadow heap.
    function automatic t_result heap_predict(logic [2:0] fn, logic [15:0] req,
                                             logic [15:0] pos);
        t_result     r;
        int unsigned addr, amt, cur, n, s;
        bit          ok;
        addr = 0;
        amt  = 0;
        ok   = 1'b0;
        case (fn)
            FN_ALLOC: begin
                ok = heap_grant(req, addr, amt);
                if (ok) held_blocks.push_back('{addr, amt});
            end
            FN_FREE: begin
                if (heap_release(pos)) begin
                    addr = pos;
                    ok   = 1'b1;
                    foreach (held_blocks[i])
                        if (held_blocks[i].pos == pos) begin
                            held_blocks.delete(i);
                            break;
                        end
                end
            end
            FN_TOTAL: begin
                cur = shadow_first;
                for (n = 0; cur < END_POS && n < STEP_CAP; n++) begin
                    amt += blk_size(cur);
                    if (amt > 16'hffff) amt = 16'hffff;
                    cur = blk_link(cur);
                end
                ok = 1'b1;
            end
            FN_LARGEST: begin
                cur = shadow_first;
                for (n = 0; cur < END_POS && n < STEP_CAP; n++) begin
                    s = blk_size(cur);
                    if (s > amt) begin
                        amt  = s;
                        addr = cur;
                        ok   = 1'b1;
                    end
                    cur = blk_link(cur);
                end
            end
            FN_SAVE: begin
                shadow_mark = shadow_first;
                addr = shadow_mark;
                ok   = 1'b1;
            end
            FN_RESTORE: begin
                shadow_first = shadow_mark;
                if (shadow_first < END_POS) begin
                    amt = END_POS - shadow_first;
                    heap_wr16(shadow_first, amt);
                    heap_wr16(shadow_first + 2, END_POS);
                    // Blocks reaching past the mark now overlap free space.
                    for (int i = held_blocks.size() - 1; i >= 0; i--)
                        if (held_blocks[i].pos + held_blocks[i].size > shadow_first)
                            held_blocks.delete(i);
                end
                addr = shadow_first;
                ok   = 1'b1;
            end
            default: ;
        endcase
        r.addr = addr[15:0];
        r.amt  = amt[15:0];
        r.ok   = ok;
        return r;
    endfunction

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_transaction(logic [2:0] fn, logic [15:0] req, logic [15:0] pos,
                                    bit typed, t_result typed_res, bit quiet);
        t_result r;
        int      gap;
        i_valid     <= 1'b1;
        i_func      <= fn;
        i_req_size  <= req;
        i_block_pos <= pos;
        do @(posedge i_clk); while (o_stall);
        r = heap_predict(fn, req, pos);
        pending_results.push_back(typed ? typed_res : r);
        gap = pick_gap(quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result checking and the watchdog.
    always @(posedge i_clk) begin
        t_result e;
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_CAP) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transaction arrived with none expected");
                err_cnt++;
            end else begin
                e = pending_results.pop_front();
                if (o_address !== e.addr) begin
                    $error("address: expected %0d, got %0d", e.addr, o_address);
                    err_cnt++;
                end
                if (o_amount !== e.amt) begin
                    $error("amount: expected %0d, got %0d", e.amt, o_amount);
                    err_cnt++;
                end
                if (o_ok !== e.ok) begin
                    $error("ok: expected %0b, got %0b", e.ok, o_ok);
                    err_cnt++;
                end
            end
        end
    end

    // Output back-pressure, in bursts, with quiet stretches.
    always @(posedge i_clk) begin
        int r;
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 2) sink_quiet <= ~sink_quiet;
            if (sink_quiet || r < 60) begin
                i_stall <= 1'b0;
            end else begin
                i_stall   <= 1'b1;
                sink_hold <= (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
            end
        end
    end

    initial begin
        t_row        rows [25];
        t_result     tr;
        int          sel;
        bit          quiet;
        logic [2:0]  fn;
        logic [15:0] req, pos;

        rows = '{
            '{FN_TOTAL,   16'd0,     16'd0,     1, 16'd0,     16'd64735, 1'b1},
            '{FN_LARGEST, 16'd0,     16'd0,     1, 16'd800,   16'd64735, 1'b1},
            '{FN_ALLOC,   16'd0,     16'd0,     1, 16'd800,   16'd2,     1'b1},
            '{FN_FREE,    16'd0,     16'd800,   1, 16'd800,   16'd0,     1'b1},
            '{FN_ALLOC,   16'hffff,  16'hffff,  1, 16'd0,     16'd0,     1'b0},
            '{FN_ALLOC,   16'd1,     16'd0,     1, 16'd800,   16'd4,     1'b1},
            '{FN_FREE,    16'd0,     16'd0,     1, 16'd0,     16'd0,     1'b0},
            '{FN_FREE,    16'd0,     16'hffff,  1, 16'd0,     16'd0,     1'b0},
            '{FN_FREE,    16'd0,     16'd804,   1, 16'd0,     16'd0,     1'b0},
            '{FN_BAD6,    16'hffff,  16'hffff,  1, 16'd0,     16'd0,     1'b0},
            '{FN_BAD7,    16'd5,     16'd900,   1, 16'd0,     16'd0,     1'b0},
            '{FN_ALLOC,   16'd101,   16'd0,     0, 16'd0,     16'd0,     1'b0},
            '{FN_FREE,    16'd0,     16'd800,   0, 16'd0,     16'd0,     1'b0},
            '{FN_SAVE,    16'd0,     16'd0,     1, 16'd800,   16'd0,     1'b1},
            '{FN_RESTORE, 16'd0,     16'd0,     1, 16'd800,   16'd64735, 1'b1},
            '{FN_ALLOC,   16'd64732, 16'd0,     1, 16'd800,   16'd64735, 1'b1},
            '{FN_LARGEST, 16'd0,     16'd0,     1, 16'd0,     16'd0,     1'b0},
            '{FN_TOTAL,   16'd0,     16'd0,     1, 16'd0,     16'd0,     1'b1},
            '{FN_ALLOC,   16'd2,     16'd0,     1, 16'd0,     16'd0,     1'b0},
            '{FN_FREE,    16'd0,     16'd800,   1, 16'd800,   16'd0,     1'b1},
            '{FN_ALLOC,   16'd64732, 16'd0,     0, 16'd0,     16'd0,     1'b0},
            '{FN_SAVE,    16'd0,     16'd0,     1, 16'd65535, 16'd0,     1'b1},
            '{FN_RESTORE, 16'd0,     16'd0,     1, 16'd65535, 16'd0,     1'b1},
            '{FN_FREE,    16'd0,     16'd800,   1, 16'd800,   16'd0,     1'b1},
            '{FN_SAVE,    16'd0,     16'd0,     1, 16'd800,   16'd0,     1'b1}
        };

        heap_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            tr = '{rows[i].addr, rows[i].amt, rows[i].ok};
            send_transaction(rows[i].fn, rows[i].req, rows[i].pos, rows[i].typed, tr, 1'b0);
        end

        quiet = 1'b0;
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 150 == 0) quiet = ($urandom_range(0, 2) == 0);
            if (k % 200 == 199) wait_drained();
            sel = $urandom_range(0, 99);
            req = 16'($urandom_range(2, 300));
            pos = 16'($urandom);
            fn  = FN_ALLOC;
            if (held_blocks.size() >= 48 && sel < 70) sel = 50;
            if (sel < 40) begin
                if ($urandom_range(0, 19) == 0) req = 16'($urandom_range(2, 65535));
                else if ($urandom_range(0, 9) == 0) req = 16'($urandom_range(301, 4000));
            end else if (sel < 75) begin
                if (held_blocks.size() > 0) begin
                    fn  = FN_FREE;
                    pos = 16'(held_blocks[$urandom_range(0, held_blocks.size() - 1)].pos);
                end
            end else if (sel < 81) begin
                // Frees that must be ignored: out of range or already free.
                fn = FN_FREE;
                case ($urandom_range(0, 2))
                    0: pos = 16'($urandom_range(0, BASE_POS - 1));
                    1: pos = 16'hffff;
                    default: pos = (shadow_first < END_POS) ? 16'(shadow_first) : 16'hffff;
                endcase
            end else if (sel < 87) begin
                fn = FN_TOTAL;
            end else if (sel < 93) begin
                fn = FN_LARGEST;
            end else if (sel < 96) begin
                fn = FN_SAVE;
            end else if (sel < 98) begin
                fn = FN_RESTORE;
            end else begin
                fn = sel[0] ? FN_BAD6 : FN_BAD7;
            end
            send_transaction(fn, req, pos, 1'b0, tr, quiet);
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/ffha_pkg.sv
sv/ffha_ram.sv
sv/ffha_dp.sv
sv/ffha_ctrl.sv
sv/first_fit_heap_allocator.sv
dv/testbench.sv
